// ===== hw/rtl/cwr_pkg.sv =====
package cwr_pkg;

    localparam int FIELD_W     = 32;
    localparam int WIN_W       = 32;
    localparam int CNT_W       = 32;
    localparam int ACC_W       = 33;
    localparam int TOT_W       = ACC_W + 1;
    localparam int PCT_W       = 7;
    // Numerator holds wake_sum * 100, which stays below 2^(ACC_W + 7).
    localparam int NUM_W       = ACC_W + PCT_W;
    localparam int QUO_STEPS   = PCT_W;
    localparam int STEP_W      = $clog2(QUO_STEPS);

    localparam logic [PCT_W-1:0] PERCENT_SCALE = PCT_W'(100);
    localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(168000000);
    localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};

    typedef struct packed {
        logic [FIELD_W-1:0] sleep_enter_time;
        logic [FIELD_W-1:0] wake_time;
    } cwr_in_t;

    typedef struct packed {
        logic               update_valid;
        logic [CNT_W-1:0]   episode_count;
        logic [PCT_W-1:0]   wake_percent;
    } cwr_out_t;

    typedef struct packed {
        logic               close;
        logic [CNT_W-1:0]   episodes;
    } cwr_acc_stat_t;

endpackage

// ===== hw/rtl/cpu_wake_ratio_monitor.sv =====
// CPU wake ratio monitor.
// Input channel (in_valid/in_ready/in_data): one beat per sleep episode with
// the cycle-counter stamps at sleep entry and at wake. Output channel
// (out_valid/out_ready/out_data): exactly one beat per input beat, carrying
// update_valid plus the held episode count and wake percentage of the last
// closed window. Configuration: cfg_wr_en/cfg_wr_data write window_cycles.
// Sequence: each input beat passes the ACCUM and CHECK states, then the DIVIDE
// state when a window closes, and EMIT loads the output register. The close path
// runs a bit-serial restoring divider, one quotient bit per cycle, after a
// scale-by-100 step. Items are taken one at a time: a new input beat is taken
// only once the sequencer is back in idle. in_ready is high while the sequencer is
// idle, also while a finished result still waits in the output register.
// Stall: when out_ready stays low, the next result waits in the sequencer until
// the output register is free; the input side then stops after one more beat.
// Reset clears the sums, counters, held stats and last wake stamp to zero and
// sets window_cycles to 168000000.
module cpu_wake_ratio_monitor #(
    parameter int STAMP_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cwr_pkg::cwr_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output cwr_pkg::cwr_out_t          out_data,
    input  logic                       cfg_wr_en,
    input  logic [cwr_pkg::WIN_W-1:0]  cfg_wr_data
);
    import cwr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ACCUM  = 5'b00010,
        S_CHECK  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    logic [WIN_W-1:0]   window_reg;
    logic [CNT_W-1:0]   held_ep_reg;
    logic [PCT_W-1:0]   held_pct_reg;
    logic               upd_reg;
    logic               out_valid_reg;
    cwr_out_t           out_reg;

    cwr_acc_stat_t      acc_stat;
    logic [ACC_W-1:0]   wake_sum;
    logic [TOT_W-1:0]   total_sum;
    logic               div_done;
    logic [PCT_W-1:0]   div_pct;

    logic               in_beat;
    logic               out_free;
    logic               div_start;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_beat   = in_valid && in_ready;
    // Output register can take a new result when empty or draining this cycle.
    assign out_free  = !out_valid_reg || out_ready;
    assign div_start = (state_reg == S_CHECK) && acc_stat.close;

    cwr_accum #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_beat),
        .in_beat   (in_data),
        .accum_en  (state_reg == S_ACCUM),
        .check_en  (state_reg == S_CHECK),
        .window    (window_reg),
        .stat      (acc_stat),
        .wake_sum  (wake_sum),
        .total_sum (total_sum)
    );

    cwr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .wake_sum  (wake_sum),
        .total_sum (total_sum),
        .done      (div_done),
        .percent   (div_pct)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_beat) state_next = S_ACCUM;
            S_ACCUM:  state_next = S_CHECK;
            S_CHECK:  state_next = acc_stat.close ? S_DIVIDE : S_EMIT;
            S_DIVIDE: if (div_done) state_next = S_EMIT;
            S_EMIT:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            held_ep_reg   <= '0;
            held_pct_reg  <= '0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end

            // Latch the episode count at window close; flag the update.
            if (state_reg == S_CHECK)
            begin
                upd_reg <= acc_stat.close;
                if (acc_stat.close)
                begin
                    held_ep_reg <= acc_stat.episodes;
                end
            end

            if ((state_reg == S_DIVIDE) && div_done)
            begin
                held_pct_reg <= div_pct;
            end

            // Hold the output beat until taken; reload when free.
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EMIT) && out_free)
        begin
            out_reg.update_valid  <= upd_reg;
            out_reg.episode_count <= held_ep_reg;
            out_reg.wake_percent  <= held_pct_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/cwr_accum.sv =====
module cwr_accum #(
    parameter int STAMP_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  cwr_pkg::cwr_in_t           in_beat,
    input  logic                       accum_en,
    input  logic                       check_en,
    input  logic [cwr_pkg::WIN_W-1:0]  window,
    output cwr_pkg::cwr_acc_stat_t     stat,
    output logic [cwr_pkg::ACC_W-1:0]  wake_sum,
    output logic [cwr_pkg::TOT_W-1:0]  total_sum
);
    import cwr_pkg::*;

    localparam int SUM_W = (STAMP_WIDTH + 1 > TOT_W) ? STAMP_WIDTH + 1 : TOT_W;
    localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'({ACC_W{1'b1}});

    logic [STAMP_WIDTH-1:0] enter_reg;
    logic [STAMP_WIDTH-1:0] wake_reg;
    logic [STAMP_WIDTH-1:0] last_wake_reg;
    logic [ACC_W-1:0]       wake_acc_reg;
    logic [ACC_W-1:0]       sleep_acc_reg;
    logic [CNT_W-1:0]       episode_reg;

    logic [STAMP_WIDTH-1:0] wake_diff;
    logic [STAMP_WIDTH-1:0] sleep_diff;
    logic [SUM_W-1:0]       wake_add;
    logic [SUM_W-1:0]       sleep_add;
    logic [ACC_W-1:0]       wake_acc_next;
    logic [ACC_W-1:0]       sleep_acc_next;
    logic [CNT_W-1:0]       episode_next;

    // Stamp differences wrap at the stamp width.
    assign wake_diff  = enter_reg - last_wake_reg;
    assign sleep_diff = wake_reg - enter_reg;
    assign wake_add   = SUM_W'(wake_acc_reg) + SUM_W'(wake_diff);
    assign sleep_add  = SUM_W'(sleep_acc_reg) + SUM_W'(sleep_diff);

    always_comb
    begin
        wake_acc_next  = (wake_add > ACC_MAX) ? {ACC_W{1'b1}} : wake_add[ACC_W-1:0];
        sleep_acc_next = (sleep_add > ACC_MAX) ? {ACC_W{1'b1}} : sleep_add[ACC_W-1:0];
        episode_next   = (episode_reg == CNT_MAX) ? episode_reg : episode_reg + CNT_W'(1);
    end

    assign wake_sum       = wake_acc_reg;
    assign total_sum      = TOT_W'(wake_acc_reg) + TOT_W'(sleep_acc_reg);
    assign stat.close     = total_sum >= TOT_W'(window);
    assign stat.episodes  = episode_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            enter_reg <= STAMP_WIDTH'(in_beat.sleep_enter_time);
            wake_reg  <= STAMP_WIDTH'(in_beat.wake_time);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_wake_reg <= '0;
            wake_acc_reg  <= '0;
            sleep_acc_reg <= '0;
            episode_reg   <= '0;
        end
        else if (accum_en)
        begin
            last_wake_reg <= wake_reg;
            wake_acc_reg  <= wake_acc_next;
            sleep_acc_reg <= sleep_acc_next;
            episode_reg   <= episode_next;
        end
        else if (check_en && stat.close)
        begin
            // Window closed: drop the sums and start a fresh count.
            wake_acc_reg  <= '0;
            sleep_acc_reg <= '0;
            episode_reg   <= '0;
        end
    end

endmodule

// ===== hw/rtl/cwr_div.sv =====
module cwr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cwr_pkg::ACC_W-1:0]  wake_sum,
    input  logic [cwr_pkg::TOT_W-1:0]  total_sum,
    output logic                       done,
    output logic [cwr_pkg::PCT_W-1:0]  percent
);
    import cwr_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_SCALE = 3'b010,
        D_STEP  = 3'b100
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic [ACC_W-1:0]   wake_reg;
    logic [TOT_W-1:0]   den_reg;
    logic               zero_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   dvs_reg;
    logic [PCT_W-1:0]   quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               done_reg;

    logic [NUM_W:0]     trial;
    logic               fits;

    // One quotient bit per cycle: trial subtract of the shifted divisor.
    assign trial = {1'b0, rem_reg} - {1'b0, dvs_reg};
    assign fits  = !trial[NUM_W];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:  if (start) state_next = D_SCALE;
            D_SCALE: state_next = D_STEP;
            D_STEP:  if (step_reg == '0) state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_STEP) && (step_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    wake_reg <= wake_sum;
                    den_reg  <= total_sum;
                    zero_reg <= (total_sum == '0);
                end
            end
            D_SCALE:
            begin
                rem_reg  <= NUM_W'(wake_reg) * NUM_W'(PERCENT_SCALE);
                dvs_reg  <= NUM_W'(den_reg) << (QUO_STEPS - 1);
                quo_reg  <= '0;
                step_reg <= STEP_W'(QUO_STEPS - 1);
            end
            D_STEP:
            begin
                if (fits)
                begin
                    rem_reg <= trial[NUM_W-1:0];
                end
                quo_reg  <= {quo_reg[PCT_W-2:0], fits};
                dvs_reg  <= dvs_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign done    = done_reg;
    assign percent = zero_reg ? '0 : quo_reg;

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (percent <= PERCENT_SCALE))
        else $error("wake percent above scale");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == D_IDLE))
        else $error("divide started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

endmodule
